/* rtl/ffc_pkg.sv */
`timescale 1ns / 1ps
package ffc_pkg;

  localparam int unsigned NODES    = 1024;
  localparam int unsigned BLOCK    = 32;
  localparam int unsigned NBLK     = (NODES + BLOCK - 1) / BLOCK;
  localparam int unsigned AW       = $clog2(NODES);
  localparam int unsigned BW       = $clog2(NBLK);
  localparam int unsigned OW       = $clog2(BLOCK);
  localparam int unsigned CW       = AW + 1;
  localparam logic [CW-1:0] NC_RESET = CW'(NODES);

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_REM   = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NONE  = 2'd3
  } func_t;

  typedef struct packed {
    logic clr;
    logic accept;
    logic v_eval;
    logic c_eval;
    logic f_dec;
    logic f_inc;
    logic q_setup;
    logic scan_fof;
    logic scan_blk;
    logic load_mid;
    logic load_tail;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clr_last;
    logic v_chg;
    logic c_ok;
    logic q_empty;
    logic q_same;
    logic q_nomid;
    logic scan_last;
    logic out_full;
  } sts_t;

endpackage

/* rtl/ffc_ctrl.sv */
`timescale 1ns / 1ps
module ffc_ctrl
  import ffc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  output logic        in_ready,
  input  sts_t        sts,
  output cmd_t        cmd
);

  typedef enum logic [11:0] {
    S_CLEAR   = 12'b0000_0000_0001,
    S_IDLE    = 12'b0000_0000_0010,
    S_V_EVAL  = 12'b0000_0000_0100,
    S_C_EVAL  = 12'b0000_0000_1000,
    S_F_DEC   = 12'b0000_0001_0000,
    S_F_INC   = 12'b0000_0010_0000,
    S_Q_SETUP = 12'b0000_0100_0000,
    S_Q_FA    = 12'b0000_1000_0000,
    S_Q_B     = 12'b0001_0000_0000,
    S_Q_FC    = 12'b0010_0000_0000,
    S_Q_DRAIN = 12'b0100_0000_0000,
    S_Q_DONE  = 12'b1000_0000_0000
  } state_t;

  state_t state_r, state_nxt;
  func_t  func_w;

  assign func_w   = func_t'(in_func);
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (func_w)
            FUNC_ADD, FUNC_REM: state_nxt = S_V_EVAL;
            FUNC_QUERY:         state_nxt = S_Q_SETUP;
            default:            state_nxt = S_IDLE;
          endcase
        end
      end
      S_V_EVAL: begin
        cmd.v_eval = 1'b1;
        state_nxt  = sts.v_chg ? S_C_EVAL : S_IDLE;
      end
      S_C_EVAL: begin
        cmd.c_eval = 1'b1;
        state_nxt  = sts.c_ok ? S_F_DEC : S_IDLE;
      end
      S_F_DEC: begin
        cmd.f_dec = 1'b1;
        state_nxt = S_F_INC;
      end
      S_F_INC: begin
        cmd.f_inc = 1'b1;
        state_nxt = S_IDLE;
      end
      S_Q_SETUP: begin
        cmd.q_setup = 1'b1;
        state_nxt   = sts.q_empty ? S_Q_DONE : S_Q_FA;
      end
      S_Q_FA: begin
        cmd.scan_fof = 1'b1;
        if (sts.scan_last) begin
          if (sts.q_same) begin
            state_nxt = S_Q_DRAIN;
          end else if (sts.q_nomid) begin
            cmd.load_tail = 1'b1;
            state_nxt     = S_Q_FC;
          end else begin
            cmd.load_mid = 1'b1;
            state_nxt    = S_Q_B;
          end
        end
      end
      S_Q_B: begin
        cmd.scan_blk = 1'b1;
        if (sts.scan_last) begin
          cmd.load_tail = 1'b1;
          state_nxt     = S_Q_FC;
        end
      end
      S_Q_FC: begin
        cmd.scan_fof = 1'b1;
        if (sts.scan_last) state_nxt = S_Q_DRAIN;
      end
      S_Q_DRAIN: begin
        state_nxt = S_Q_DONE;
      end
      S_Q_DONE: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/ffc_dpath.sv */
`timescale 1ns / 1ps
module ffc_dpath
  import ffc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  output sts_t          sts,
  input  logic [1:0]    in_func,
  input  logic [AW-1:0] in_node,
  input  logic [AW-1:0] in_color,
  input  logic [CW-1:0] in_threshold,
  input  logic          cfg_valid,
  input  logic [CW-1:0] cfg_data,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CW-1:0] out_color_total
);

  logic [1:0]    vis_mem [NODES];
  logic [CW-1:0] cnt_mem [NODES];
  logic [CW-1:0] fof_mem [NODES];
  logic [CW-1:0] bs_mem  [NBLK];

  logic [1:0]    vis_q;
  logic [CW-1:0] cnt_q, fof_q, bs_q;

  logic [CW-1:0] nc_r;
  logic [AW-1:0] clr_r;
  logic [AW-1:0] node_r, color_r;
  logic          add_r;
  logic [CW-1:0] thr_r;
  logic [CW-1:0] fold_r, fnew_r;
  logic [AW-1:0] ptr_r, end_r;
  logic [BW-1:0] lb_r, rb_r;
  logic [AW-1:0] n1_r;
  logic          same_r, nomid_r;
  logic          pend_r, psel_r;
  logic [CW-1:0] acc_r;
  logic          out_valid_r;
  logic [CW-1:0] out_total_r;

  logic [1:0]    vis_new;
  logic          vis_ign, v_chg;
  logic          c_ok;
  logic [CW-1:0] c_new;
  logic [AW-1:0] cold_a, fnew_a, fold_a;
  logic          bdec, binc;
  logic [CW-1:0] k_w, n_w;
  logic [AW-1:0] k0_w, n1_w;
  logic [BW-1:0] lb_w, rb_w;
  logic          same_w;

  logic          vis_we, cnt_we, fof_we, bs_we;
  logic [AW-1:0] vis_wa, cnt_wa, fof_wa, fof_ra;
  logic [BW-1:0] bs_wa, bs_ra;
  logic [1:0]    vis_wd;
  logic [CW-1:0] cnt_wd, fof_wd, bs_wd;
  logic [AW-1:0] vis_ra, cnt_ra;

  always_comb begin
    if (add_r) begin
      vis_ign = (vis_q >= 2'd2);
      vis_new = vis_q + 2'd1;
      v_chg   = !vis_ign && (vis_new == 2'd2);
    end else begin
      vis_ign = (vis_q == 2'd0);
      vis_new = vis_q - 2'd1;
      v_chg   = !vis_ign && (vis_new == 2'd1);
    end
  end

  assign c_ok   = add_r ? (cnt_q < CW'(NODES)) : (cnt_q != '0);
  assign c_new  = add_r ? cnt_q + CW'(1) : cnt_q - CW'(1);
  assign cold_a = AW'(cnt_q - CW'(1));
  assign fold_a = AW'(fold_r - CW'(1));
  assign fnew_a = AW'(fnew_r - CW'(1));
  assign bdec   = (fold_r != '0) &&
                  ((fnew_r == '0) || (fold_a[AW-1 -: BW] != fnew_a[AW-1 -: BW]));
  assign binc   = (fnew_r != '0) &&
                  ((fold_r == '0) || (fold_a[AW-1 -: BW] != fnew_a[AW-1 -: BW]));

  assign k_w    = (thr_r == '0) ? CW'(1) : thr_r;
  assign n_w    = (nc_r > CW'(NODES)) ? CW'(NODES) : nc_r;
  assign k0_w   = AW'(k_w - CW'(1));
  assign n1_w   = AW'(n_w - CW'(1));
  assign lb_w   = k0_w[AW-1 -: BW];
  assign rb_w   = n1_w[AW-1 -: BW];
  assign same_w = (lb_w == rb_w);

  assign sts.clr_last  = (clr_r == AW'(NODES - 1));
  assign sts.v_chg     = v_chg;
  assign sts.c_ok      = c_ok;
  assign sts.q_empty   = (k_w > n_w);
  assign sts.q_same    = same_r;
  assign sts.q_nomid   = nomid_r;
  assign sts.scan_last = (ptr_r == end_r);
  assign sts.out_full  = out_valid_r;

  always_comb begin
    vis_ra = cmd.accept ? in_node : node_r;
    cnt_ra = color_r;
    fof_ra = ptr_r;
    bs_ra  = ptr_r[BW-1:0];
    if (cmd.c_eval) begin
      fof_ra = cold_a;
      bs_ra  = cold_a[AW-1 -: BW];
    end else if (cmd.f_dec) begin
      fof_ra = fnew_a;
      bs_ra  = fnew_a[AW-1 -: BW];
    end

    vis_we = 1'b0;
    vis_wa = node_r;
    vis_wd = vis_new;
    cnt_we = 1'b0;
    cnt_wa = color_r;
    cnt_wd = c_new;
    fof_we = 1'b0;
    fof_wa = fold_a;
    fof_wd = fof_q - CW'(1);
    bs_we  = 1'b0;
    bs_wa  = fold_a[AW-1 -: BW];
    bs_wd  = bs_q - CW'(1);
    if (cmd.clr) begin
      vis_we = 1'b1;
      vis_wa = clr_r;
      vis_wd = '0;
      cnt_we = 1'b1;
      cnt_wa = clr_r;
      cnt_wd = '0;
      fof_we = 1'b1;
      fof_wa = clr_r;
      fof_wd = '0;
      bs_we  = 1'b1;
      bs_wa  = clr_r[BW-1:0];
      bs_wd  = '0;
    end else if (cmd.v_eval) begin
      vis_we = !vis_ign;
    end else if (cmd.c_eval) begin
      cnt_we = c_ok;
    end else if (cmd.f_dec) begin
      fof_we = (fold_r != '0);
      bs_we  = bdec;
    end else if (cmd.f_inc) begin
      fof_we = (fnew_r != '0);
      fof_wa = fnew_a;
      fof_wd = fof_q + CW'(1);
      bs_we  = binc;
      bs_wa  = fnew_a[AW-1 -: BW];
      bs_wd  = bs_q + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_wa] <= vis_wd;
    vis_q <= vis_mem[vis_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_q <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (fof_we) fof_mem[fof_wa] <= fof_wd;
    fof_q <= fof_mem[fof_ra];
  end

  always_ff @(posedge clk) begin
    if (bs_we) bs_mem[bs_wa] <= bs_wd;
    bs_q <= bs_mem[bs_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r        <= NC_RESET;
      clr_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) nc_r <= cfg_data;
      if (cmd.clr) clr_r <= clr_r + AW'(1);
      pend_r <= cmd.scan_fof | cmd.scan_blk;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    psel_r <= cmd.scan_blk;
    if (cmd.accept) begin
      node_r  <= in_node;
      color_r <= in_color;
      add_r   <= (func_t'(in_func) == FUNC_ADD);
      thr_r   <= in_threshold;
    end
    if (cmd.c_eval) begin
      fold_r <= cnt_q;
      fnew_r <= c_new;
    end
    if (cmd.q_setup) begin
      lb_r    <= lb_w;
      rb_r    <= rb_w;
      n1_r    <= n1_w;
      same_r  <= same_w;
      nomid_r <= (rb_w == lb_w + BW'(1));
      ptr_r   <= k0_w;
      end_r   <= same_w ? n1_w : {lb_w, {OW{1'b1}}};
    end else if (cmd.load_mid) begin
      ptr_r <= AW'(lb_r + BW'(1));
      end_r <= AW'(rb_r - BW'(1));
    end else if (cmd.load_tail) begin
      ptr_r <= {rb_r, {OW{1'b0}}};
      end_r <= n1_r;
    end else if (cmd.scan_fof || cmd.scan_blk) begin
      ptr_r <= ptr_r + AW'(1);
    end
    if (cmd.q_setup) begin
      acc_r <= '0;
    end else if (pend_r) begin
      acc_r <= acc_r + (psel_r ? bs_q : fof_q);
    end
    if (cmd.out_load) out_total_r <= acc_r;
  end

  assign out_valid       = out_valid_r;
  assign out_color_total = out_total_r;

endmodule

/* rtl/frequency_of_frequency_counter_unit.sv */
// An update evaluates the visit count and ends if the colour is left alone, then the colour
// count and ends if it cannot move, else moves the colour from its old bin to its new one;
// an unknown operation is just taken. A query ends at once for an empty range, else it reads
// the bins and block sums for 1024 nodes in blocks of 32 and may wait on the output register.
// The result sits in an output register, so the next beat is taken before it drains.
// After reset a clearing pass zeroes all stores; configuration is always taken.
`timescale 1ns / 1ps
module frequency_of_frequency_counter_unit
  import ffc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [1:0]    in_func,
  input  logic [AW-1:0] in_node,
  input  logic [AW-1:0] in_color,
  input  logic [CW-1:0] in_threshold,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [CW-1:0] out_color_total,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [CW-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  ffc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_func  (in_func),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  ffc_dpath u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_func         (in_func),
    .in_node         (in_node),
    .in_color        (in_color),
    .in_threshold    (in_threshold),
    .cfg_valid       (cfg_valid),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_total (out_color_total)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ready)
    else $error("input taken during clearing pass");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !out_valid)
    else $error("result register overwritten");

  a_single_scan: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_fof && cmd.scan_blk))
    else $error("two scans at once");

  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (func_t'(in_func) != FUNC_NONE)) |=> !in_ready)
    else $error("accepted beat did not start work");

endmodule

/* sim/ffc_result_checker.sv */
`timescale 1ns / 1ps
module ffc_result_checker
  import ffc_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [1:0]    in_func,
  input  logic [AW-1:0] in_node,
  input  logic [AW-1:0] in_color,
  input  logic [CW-1:0] in_threshold,
  input  logic          out_valid,
  input  logic          out_ready,
  input  logic [CW-1:0] out_color_total,
  input  logic          cfg_valid,
  input  logic          cfg_ready,
  input  logic [CW-1:0] cfg_data,
  output int            fail_count,
  output int            pending_totals,
  output int            query_count
);

  logic [1:0]    visits [NODES];
  logic [CW-1:0] hue_count [NODES];
  int            bin_fill [NODES+1];
  int            block_fill [NBLK+1];
  logic [CW-1:0] upper_freq;
  logic [CW-1:0] total_queue [$];

  function automatic int block_index(int f);
    return (f + BLOCK - 1) / BLOCK;
  endfunction

  function automatic void shift_bin(int f, int delta);
    if (f >= 1 && f <= NODES) begin
      bin_fill[f] += delta;
      block_fill[block_index(f)] += delta;
    end
  endfunction

  function automatic logic [CW-1:0] count_at_least(int k);
    int n, sum, lb, rb;
    n = (upper_freq > NODES) ? NODES : int'(upper_freq);
    sum = 0;
    if (k == 0) k = 1;
    if (k > n) return '0;
    lb = block_index(k);
    rb = block_index(n);
    if (lb == rb) begin
      for (int i = k; i <= n; i++) sum += bin_fill[i];
    end else begin
      for (int i = k; i <= lb * BLOCK; i++) sum += bin_fill[i];
      for (int b = lb + 1; b < rb; b++) sum += block_fill[b];
      for (int i = (rb - 1) * BLOCK + 1; i <= n; i++) sum += bin_fill[i];
    end
    return CW'(sum);
  endfunction

  function automatic void apply_sighting(func_t f, int nd, int c);
    int cnt;
    cnt = hue_count[c];
    if (f == FUNC_ADD) begin
      if (visits[nd] >= 2) return;
      visits[nd]++;
      if (visits[nd] == 2 && cnt < NODES) begin
        shift_bin(cnt, -1);
        hue_count[c] = CW'(cnt + 1);
        shift_bin(cnt + 1, 1);
      end
    end else begin
      if (visits[nd] == 0) return;
      visits[nd]--;
      if (visits[nd] == 1 && cnt > 0) begin
        shift_bin(cnt, -1);
        hue_count[c] = CW'(cnt - 1);
        shift_bin(cnt - 1, 1);
      end
    end
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      foreach (visits[i]) visits[i] = '0;
      foreach (hue_count[i]) hue_count[i] = '0;
      foreach (bin_fill[i]) bin_fill[i] = 0;
      foreach (block_fill[i]) block_fill[i] = 0;
      upper_freq <= NC_RESET;
      total_queue.delete();
      fail_count <= 0;
      pending_totals <= 0;
      query_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) upper_freq <= cfg_data;
      if (in_valid && in_ready) begin
        if (func_t'(in_func) == FUNC_QUERY)
          total_queue.insert(total_queue.size(), count_at_least(in_threshold));
        else if (func_t'(in_func) != FUNC_NONE)
          apply_sighting(func_t'(in_func), in_node, in_color);
      end
      if (out_valid && out_ready) begin
        query_count <= query_count + 1;
        if (total_queue.size() == 0) begin
          if (fail_count < 10) $display("Unexpected beat: color_total %0d", out_color_total);
          fail_count <= fail_count + 1;
        end else begin
          if (out_color_total !== total_queue[0]) begin
            if (fail_count < 10)
              $display("Mismatch: color_total expected %0d, got %0d",
                       total_queue[0], out_color_total);
            fail_count <= fail_count + 1;
          end
          void'(total_queue.pop_front());
        end
      end
      pending_totals <= total_queue.size();
    end
  end

endmodule

/* sim/frequency_of_frequency_counter_unit_test.sv */
`timescale 1ns / 1ps
module frequency_of_frequency_counter_unit_test;
  import ffc_pkg::*;

  logic          clk = 0;
  logic          rst_n = 0;
  logic          in_valid = 0, out_ready = 0, cfg_valid = 0;
  logic          in_ready, out_valid, cfg_ready;
  logic [1:0]    in_func = '0;
  logic [AW-1:0] in_node = '0, in_color = '0;
  logic [CW-1:0] in_threshold = '0, cfg_data = '0, out_color_total;
  int            fail_count, pending_totals, query_count;
  int            idle_cycles = 0;
  int            items_sent = 0;
  int            hot_nodes [16];

  always #5 clk = ~clk;

  frequency_of_frequency_counter_unit dut (.*);

  ffc_result_checker checker_i (.*);

  function automatic int random_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_item(func_t f, int nd, int c, int k);
    int gap;
    gap = random_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_func <= f;
    in_node <= AW'(nd);
    in_color <= AW'(c);
    in_threshold <= CW'(k);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain_all();
    in_valid <= 0;
    @(posedge clk);
    while (pending_totals != 0 || !in_ready) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_limit(int v);
    cfg_valid <= 1;
    cfg_data <= CW'(v);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
  endtask

  task automatic random_phase(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_item(FUNC_ADD, hot_nodes[$urandom_range(0, 15)], $urandom_range(0, 7), 0);
      else if (r < 60)
        send_item(FUNC_REM, hot_nodes[$urandom_range(0, 15)], $urandom_range(0, 7), 0);
      else if (r < 70)
        send_item(func_t'($urandom_range(0, 1)), $urandom_range(0, 1023),
                  $urandom_range(0, 1023), $urandom_range(0, 2047));
      else if (r < 95)
        send_item(FUNC_QUERY, $urandom, $urandom,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 6));
      else
        send_item(FUNC_NONE, $urandom, $urandom, $urandom);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 0;
    else if ($urandom_range(0, 99) < 8) out_ready <= 0;
    else if ($urandom_range(0, 99) < 40) out_ready <= 1;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    foreach (hot_nodes[i]) hot_nodes[i] = $urandom_range(0, 1023);
    hot_nodes[0] = 0;
    hot_nodes[1] = 1023;
    repeat (2) @(posedge clk);
    rst_n <= 1;
    send_item(FUNC_QUERY, 0, 0, 1);
    send_item(FUNC_ADD, 0, 0, 0);
    send_item(FUNC_ADD, 0, 0, 0);
    send_item(FUNC_ADD, 0, 0, 0);
    send_item(FUNC_ADD, 1023, 1023, 0);
    send_item(FUNC_ADD, 1023, 1023, 0);
    send_item(FUNC_ADD, 5, 0, 0);
    send_item(FUNC_ADD, 5, 0, 0);
    send_item(FUNC_QUERY, 1023, 1023, 0);
    send_item(FUNC_QUERY, 0, 0, 2);
    send_item(FUNC_QUERY, 0, 0, 1024);
    send_item(FUNC_QUERY, 0, 0, 2047);
    send_item(FUNC_REM, 5, 0, 0);
    send_item(FUNC_REM, 5, 0, 0);
    send_item(FUNC_REM, 5, 0, 0);
    send_item(FUNC_REM, 7, 3, 0);
    send_item(FUNC_ADD, 9, 4, 0);
    send_item(FUNC_ADD, 9, 4, 0);
    send_item(FUNC_REM, 9, 4, 0);
    send_item(FUNC_NONE, 1023, 1023, 2047);
    send_item(FUNC_QUERY, 0, 0, 1);
    drain_all();
    write_limit(0);
    send_item(FUNC_QUERY, 0, 0, 1);
    drain_all();
    write_limit(2047);
    random_phase(250);
    drain_all();
    write_limit(1);
    random_phase(150);
    drain_all();
    write_limit(40);
    random_phase(300);
    drain_all();
    write_limit(1024);
    random_phase(300);
    drain_all();
    $display("Ran %0d input beats and checked %0d result beats over five limit settings.",
             items_sent, query_count);
    if (fail_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
